>>> sv/ncrs_pkg.sv
// ----------------------------------------------------------------------------
// ncrs_pkg
// Shared types and constants for the nearest cell ring search block.
// ----------------------------------------------------------------------------
package ncrs_pkg;

    // Grid geometry and search reach.
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int MAX_RADIUS  = 10;

    // Field widths fixed by the item format.
    localparam int XY_W    = 6;
    localparam int CLASS_W = 2;

    // Grid store geometry.
    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Radius counter width, and a signed width that holds any ring coordinate
    // from -MAX_RADIUS up to the largest centre plus MAX_RADIUS.
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int COORD_W = $clog2((1 << XY_W) + MAX_RADIUS) + 1;

    // Item commands.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } ncrs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch a new item, write the grid for a write item
        logic step;      // issue the current ring cell and advance the scan
        logic take_hit;  // capture the matching cell as the result
        logic out_load;  // move the result into the output register
    } ncrs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;        // the cell under check holds the target class
        logic chk_pending;  // a grid read is in flight
        logic scan_done;    // the last cell of the last ring has been issued
    } ncrs_stat_t;

endpackage

>>> sv/ncrs_ram.sv
// ----------------------------------------------------------------------------
// ncrs_ram
// Generic memory with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ncrs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ncrs_ctrl.sv
// ----------------------------------------------------------------------------
// ncrs_ctrl
// Controller: sequences item acceptance, the ring scan and result hand-off.
// ----------------------------------------------------------------------------
module ncrs_ctrl
    import ncrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    input  ncrs_stat_t stat,
    output ncrs_cmd_t  ctl
);

    ncrs_state_t state_reg;
    ncrs_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = (cmd == CMD_SEARCH) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    ctl.take_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else if (stat.scan_done)
                begin
                    // Every ring cell has been checked without a match.
                    if (!stat.chk_pending)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output item stays valid until it is taken.
    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sv/ncrs_datapath.sv
// ----------------------------------------------------------------------------
// ncrs_datapath
// Datapath: class grid memory, ring scan counters, match check and result
// registers.
// ----------------------------------------------------------------------------
module ncrs_datapath
    import ncrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ncrs_cmd_t          ctl,
    output ncrs_stat_t         stat,
    input  logic               cmd,
    input  logic [XY_W-1:0]    cell_x,
    input  logic [XY_W-1:0]    cell_y,
    input  logic [CLASS_W-1:0] class_code,
    output logic               found,
    output logic [XY_W-1:0]    hit_x,
    output logic [XY_W-1:0]    hit_y
);

    // Item registers.
    logic [XY_W-1:0]    cx_reg;
    logic [XY_W-1:0]    cy_reg;
    logic [CLASS_W-1:0] tgt_reg;

    // Scan position: radius, offset along the side, side and phase.
    logic [RAD_W-1:0]          r_reg,    r_next;
    logic signed [COORD_W-1:0] k_reg,    k_next;
    logic                      side_reg, side_next;
    logic                      row_reg,  row_next;
    logic                      done_reg, done_next;

    // Check stage, aligned with the registered memory read.
    logic               chk_valid_reg;
    logic [XY_W-1:0]    chk_x_reg;
    logic [XY_W-1:0]    chk_y_reg;

    // Result and output registers.
    logic               res_found_reg;
    logic [XY_W-1:0]    res_x_reg;
    logic [XY_W-1:0]    res_y_reg;
    logic               out_found_reg;
    logic [XY_W-1:0]    out_x_reg;
    logic [XY_W-1:0]    out_y_reg;

    // Combinational scan signals.
    logic signed [COORD_W-1:0] r_s;
    logic signed [COORD_W-1:0] cx_s;
    logic signed [COORD_W-1:0] cy_s;
    logic signed [COORD_W-1:0] offs;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      in_grid;
    logic                      last_cell;
    logic [ADDR_W-1:0]         rd_addr;
    logic [CLASS_W-1:0]        rd_data;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;

    // Grid write on acceptance of a write item that lands inside the grid.
    assign wr_en   = ctl.accept && (cmd == CMD_WRITE)
                     && (int'(cell_x) < GRID_WIDTH) && (int'(cell_y) < GRID_HEIGHT);
    assign wr_addr = ADDR_W'(int'(cell_y) * GRID_WIDTH + int'(cell_x));

    // Current ring cell: columns first, then rows.
    always_comb
    begin
        r_s  = signed'(COORD_W'(r_reg));
        cx_s = signed'(COORD_W'(cx_reg));
        cy_s = signed'(COORD_W'(cy_reg));
        offs = side_reg ? r_s : -r_s;
        if (!row_reg)
        begin
            px = cx_s + offs;
            py = cy_s + k_reg;
        end
        else
        begin
            px = cx_s + k_reg;
            py = cy_s + offs;
        end
        in_grid = (int'(px) >= 0) && (int'(px) < GRID_WIDTH)
                  && (int'(py) >= 0) && (int'(py) < GRID_HEIGHT);
        rd_addr   = ADDR_W'(int'(py) * GRID_WIDTH + int'(px));
        last_cell = (k_reg == r_s) && side_reg && row_reg
                    && (int'(r_reg) == MAX_RADIUS);
    end

    // Scan advance: k runs -r..r, then side, then phase, then radius.
    always_comb
    begin
        r_next    = r_reg;
        k_next    = k_reg;
        side_next = side_reg;
        row_next  = row_reg;
        done_next = done_reg;
        if (ctl.accept)
        begin
            r_next    = RAD_W'(1);
            k_next    = -COORD_W'(1);
            side_next = 1'b0;
            row_next  = 1'b0;
            done_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (last_cell)
            begin
                done_next = 1'b1;
            end
            if (k_reg != r_s)
            begin
                k_next = k_reg + COORD_W'(1);
            end
            else
            begin
                side_next = !side_reg;
                if (side_reg)
                begin
                    row_next = !row_reg;
                end
                if (side_reg && row_reg)
                begin
                    r_next = r_reg + RAD_W'(1);
                    k_next = -(r_s + COORD_W'(1));
                end
                else
                begin
                    k_next = -r_s;
                end
            end
        end
    end

    // Control-like scan registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            chk_valid_reg <= ctl.step && in_grid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        k_reg     <= k_next;
        side_reg  <= side_next;
        row_reg   <= row_next;
        chk_x_reg <= px[XY_W-1:0];
        chk_y_reg <= py[XY_W-1:0];
        if (ctl.accept)
        begin
            cx_reg        <= cell_x;
            cy_reg        <= cell_y;
            tgt_reg       <= class_code;
            res_found_reg <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
        end
        else if (ctl.take_hit)
        begin
            res_found_reg <= 1'b1;
            res_x_reg     <= chk_x_reg;
            res_y_reg     <= chk_y_reg;
        end
        if (ctl.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_x_reg     <= res_x_reg;
            out_y_reg     <= res_y_reg;
        end
    end

    // Class grid store.
    ncrs_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (class_code),
        .rd_en   (ctl.step && in_grid),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Status back to the controller.
    assign stat.match       = chk_valid_reg && (rd_data == tgt_reg);
    assign stat.chk_pending = chk_valid_reg;
    assign stat.scan_done   = done_reg;

    assign found = out_found_reg;
    assign hit_x = out_x_reg;
    assign hit_y = out_y_reg;

endmodule

>>> sv/nearest_cell_ring_search.sv
// ----------------------------------------------------------------------------
// nearest_cell_ring_search
// Grid of 2-bit class codes with a nearest-match search over square rings.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ---------------------------------------
//  in       in_valid / in_ready    cmd, cell_x, cell_y, class_code
//  out      out_valid / out_ready  found, hit_x, hit_y
//
// A write item passes from idle to the done state and returns found clear. A
// search item reads one ring cell per cycle through the single grid read port:
// ring r holds 8r+4 scan positions, and the scan runs from ring 1 out to
// MAX_RADIUS, stopping early when a match is found. Reset clears the controller
// and the output valid; the grid contents are undefined until written. A new
// item is taken while a finished result waits in the output register; a stalled
// output holds the block only once the next result is also finished.
//
module nearest_cell_ring_search
    import ncrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [XY_W-1:0]    cell_x,
    input  logic [XY_W-1:0]    cell_y,
    input  logic [CLASS_W-1:0] class_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [XY_W-1:0]    hit_x,
    output logic [XY_W-1:0]    hit_y
);

    ncrs_cmd_t  ctl;
    ncrs_stat_t stat;

    // Sequencing of items and the ring scan.
    ncrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Grid storage, scan counters and result registers.
    ncrs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .class_code (class_code),
        .found      (found),
        .hit_x      (hit_x),
        .hit_y      (hit_y)
    );

endmodule
